/* rtl/fpa_pkg.sv */
// shared op codes, widths and pipeline types for the q24.8 fixed-point alu
`default_nettype none
package fpa_pkg;
	localparam int DATA_W = 32;
	localparam int OP_W   = 4;

	localparam logic [OP_W-1:0] OP_ADD  = 4'd0;
	localparam logic [OP_W-1:0] OP_SUB  = 4'd1;
	localparam logic [OP_W-1:0] OP_MUL  = 4'd2;
	localparam logic [OP_W-1:0] OP_DIV  = 4'd3;
	localparam logic [OP_W-1:0] OP_MIN  = 4'd4;
	localparam logic [OP_W-1:0] OP_MAX  = 4'd5;
	localparam logic [OP_W-1:0] OP_INC  = 4'd6;
	localparam logic [OP_W-1:0] OP_DEC  = 4'd7;
	localparam logic [OP_W-1:0] OP_ITOF = 4'd8;
	localparam logic [OP_W-1:0] OP_FTOI = 4'd9;

	// per-item data that rides alongside the divider stages
	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic signed [DATA_W-1:0] res;
		logic                     lt;
		logic                     eq;
		logic                     gt;
		logic                     quot_neg;
		logic                     dz;
	} fpa_side_t;
endpackage
`default_nettype wire

/* rtl/fpa_if.sv */
// request and response channel interfaces
`default_nettype none
interface fpa_req_if;
	import fpa_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          op;
	logic signed [DATA_W-1:0] operand_a;
	logic signed [DATA_W-1:0] operand_b;
	modport source (output valid, op, operand_a, operand_b, input ready);
	modport sink (input valid, op, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if;
	import fpa_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] result;
	logic                     a_less;
	logic                     a_equal;
	logic                     a_greater;
	logic                     div_by_zero;
	modport source (output valid, result, a_less, a_equal, a_greater, div_by_zero,
		input ready);
	modport sink (input valid, result, a_less, a_equal, a_greater, div_by_zero,
		output ready);
endinterface
`default_nettype wire

/* rtl/fpa_div.sv */
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module fpa_div
	import fpa_pkg::*;
#(
	parameter int QUOT_W = 40
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [QUOT_W-1:0] dividend,
	input  wire logic [DATA_W-1:0] divisor,
	output logic      [QUOT_W-1:0] quotient
);
	logic [DATA_W-1:0] rem_s [0:QUOT_W];
	logic [QUOT_W-1:0] dq_s  [0:QUOT_W];
	logic [DATA_W-1:0] dvs_s [0:QUOT_W];

	assign rem_s[0] = '0;
	assign dq_s[0]  = dividend;
	assign dvs_s[0] = divisor;

	for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
		logic [DATA_W:0] trial;
		logic            ge;
		// divisor never exceeds 2^31, so the remainder fits in DATA_W bits
		assign trial = {rem_s[k], dq_s[k][QUOT_W-1]};
		assign ge    = trial >= {1'b0, dvs_s[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? DATA_W'(trial - {1'b0, dvs_s[k]}) : trial[DATA_W-1:0];
				dq_s[k+1]  <= {dq_s[k][QUOT_W-2:0], ge};
				dvs_s[k+1] <= dvs_s[k];
			end
		end
	end

	assign quotient = dq_s[QUOT_W];
endmodule
`default_nettype wire

/* rtl/fixed_point_alu_q24_8.sv */
// top level of the pipelined q24.8 fixed-point alu
//  channel | dir | fields                                             | handshake
//  req     | in  | op, operand_a, operand_b                           | valid/ready
//  rsp     | out | result, a_less, a_equal, a_greater, div_by_zero    | valid/ready
// one item per cycle while the output register is empty or taken; the divider
// resolves one quotient bit per stage
// arst_n clears every valid bit; payload registers are not reset
// the whole pipeline advances together when the output register is empty or taken
`default_nettype none
module fixed_point_alu_q24_8
	import fpa_pkg::*;
#(
	parameter int FRACTION_BITS = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	fpa_req_if.sink   req,
	fpa_rsp_if.source rsp
);
	localparam int QUOT_W = DATA_W + FRACTION_BITS;
	localparam logic [DATA_W-1:0] NEG_ONE = ~((DATA_W'(1) << FRACTION_BITS) - DATA_W'(1));

	logic en;
	assign en = !rsp.valid || rsp.ready;
	assign req.ready = en;

	// input stage
	logic                     v_s1;
	logic [OP_W-1:0]          op_s1;
	logic signed [DATA_W-1:0] a_s1, b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= req.op;
			a_s1  <= req.operand_a;
			b_s1  <= req.operand_b;
		end
	end

	// simple ops, flags and divider operands
	fpa_side_t         side_in;
	logic [DATA_W-1:0] abs_a, abs_b;

	always_comb begin
		side_in.op       = op_s1;
		side_in.lt       = a_s1 < b_s1;
		side_in.eq       = a_s1 == b_s1;
		side_in.gt       = a_s1 > b_s1;
		side_in.quot_neg = a_s1[DATA_W-1] ^ b_s1[DATA_W-1];
		side_in.dz       = (op_s1 == OP_DIV) && (b_s1 == '0);
		case (op_s1)
			OP_ADD:  side_in.res = a_s1 + b_s1;
			OP_SUB:  side_in.res = a_s1 - b_s1;
			OP_MIN:  side_in.res = (a_s1 < b_s1) ? a_s1 : b_s1;
			OP_MAX:  side_in.res = (a_s1 > b_s1) ? a_s1 : b_s1;
			OP_INC:  side_in.res = a_s1 + DATA_W'(1);
			OP_DEC:  side_in.res = a_s1 - DATA_W'(1);
			OP_ITOF: side_in.res = a_s1 <<< FRACTION_BITS;
			OP_FTOI: side_in.res = a_s1 >>> FRACTION_BITS;
			default: side_in.res = '0;
		endcase
		abs_a = a_s1[DATA_W-1] ? DATA_W'(-a_s1) : a_s1;
		abs_b = b_s1[DATA_W-1] ? DATA_W'(-b_s1) : b_s1;
	end

	logic [QUOT_W-1:0] quotient;

	fpa_div #(.QUOT_W(QUOT_W)) u_div (
		.clk      (clk),
		.en       (en),
		.dividend ({abs_a, FRACTION_BITS'(0)}),
		.divisor  (abs_b),
		.quotient (quotient)
	);

	// side pipe, aligned with the divider stages
	fpa_side_t                  side_s [0:QUOT_W-1];
	logic      [QUOT_W-1:0]     v_side;
	logic signed [2*DATA_W-1:0] prod_s2;
	fpa_side_t                  side_mul;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_side <= '0;
		end else if (en) begin
			v_side <= {v_side[QUOT_W-2:0], v_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			prod_s2   <= a_s1 * b_s1;
		end
	end

	// product lands one stage after the multiply register
	always_comb begin
		side_mul = side_s[0];
		if (side_s[0].op == OP_MUL) begin
			side_mul.res = prod_s2[FRACTION_BITS+DATA_W-1:FRACTION_BITS];
		end
	end

	for (genvar k = 1; k < QUOT_W; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= (k == 1) ? side_mul : side_s[k-1];
			end
		end
	end

	// output register
	fpa_side_t         last;
	logic [QUOT_W-1:0] signed_q;
	logic [DATA_W-1:0] res_out;

	always_comb begin
		last     = side_s[QUOT_W-1];
		signed_q = last.quot_neg ? QUOT_W'(-quotient) : quotient;
		if (last.op == OP_DIV) begin
			res_out = last.dz ? NEG_ONE : signed_q[DATA_W-1:0];
		end else begin
			res_out = last.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (en) begin
			rsp.valid <= v_side[QUOT_W-1];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			rsp.result      <= res_out;
			rsp.a_less      <= last.lt;
			rsp.a_equal     <= last.eq;
			rsp.a_greater   <= last.gt;
			rsp.div_by_zero <= last.dz;
		end
	end

	a_dz_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.div_by_zero |-> rsp.result == NEG_ONE)
		else $error("divide by zero beat without the minus one result");
	a_flags_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> $onehot({rsp.a_less, rsp.a_equal, rsp.a_greater}))
		else $error("compare flags not one-hot");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_side) && $stable(v_s1))
		else $error("pipeline moved during a stall");
endmodule
`default_nettype wire
